// ===== src/kmds_pkg.sv =====
// Shared types, constants and the key priority table for the key matrix scanner.
// Used by kmds_prio_enc and key_matrix_debounced_scanner; depends on nothing else.
package kmds_pkg;

    // Number of keys that the fixed priority table holds.
    localparam int TABLE_SIZE = 52;
    // Default key count; only the first TABLE_SIZE table keys are looked at.
    localparam int KEY_TOTAL_DEF = 58;
    // Reset value of the settle time register, in ticks.
    localparam logic [15:0] SETTLE_RESET = 16'd900;

    // Register byte addresses on the configuration port.
    localparam logic [0:0] ADDR_SETTLE_TICKS = 1'b0;

    // Matrix bit position (row * 8 + col) of each key, in priority order.
    localparam logic [5:0] KEY_POS [TABLE_SIZE] = '{
        6'd8,  6'd0,  6'd38, 6'd29, 6'd5,  6'd39,
        6'd17, 6'd35, 6'd34, 6'd18, 6'd49, 6'd42, 6'd19, 6'd43, 6'd12, 6'd20,
        6'd44, 6'd21, 6'd36, 6'd60, 6'd52, 6'd13, 6'd55, 6'd10,
        6'd41, 6'd50, 6'd51, 6'd59, 6'd9,  6'd58, 6'd11, 6'd33,
        6'd28, 6'd7,  6'd31, 6'd1,  6'd25, 6'd2,  6'd26, 6'd3,  6'd27, 6'd4,
        6'd56, 6'd14, 6'd22, 6'd37, 6'd45, 6'd46, 6'd53, 6'd54, 6'd61, 6'd62
    };

    // Scanner phases.
    typedef enum logic [1:0] {
        PH_RELEASE = 2'd0,
        PH_SETTLE  = 2'd1,
        PH_SCAN    = 2'd2,
        PH_CONFIRM = 2'd3
    } kmds_phase_t;

    // Results of the priority encoder for one snapshot.
    typedef struct packed {
        logic       found;      // some table key is held
        logic [5:0] index;      // first held key in priority order
        logic       held_ok;    // the remembered key is still held
    } kmds_enc_t;

    // Matrix position of a table entry; entries beyond the table give zero.
    function automatic logic [5:0] key_pos(input logic [5:0] idx);
        logic [5:0] pos;
        pos = 6'd0;
        if (idx < 6'(TABLE_SIZE))
        begin
            pos = KEY_POS[idx];
        end
        return pos;
    endfunction

endpackage

// ===== src/key_matrix_debounced_scanner.sv =====
// Top level of the debounced 8 by 8 key matrix scanner: input register, phase
// machine, result register and APB register. Depends on kmds_pkg and kmds_prio_enc.
//
//  Channel  | Signals                                  | Direction | Moves
//  ---------+------------------------------------------+-----------+------------------------
//  input    | in_valid, in_stall, key_lines            | in        | one snapshot per request
//  result   | out_valid, out_stall, key_index/row/col, | out       | one confirmed key per
//           | entropy_count                            |           | request
//  config   | psel, penable, pwrite, paddr, pwdata,    | in/out    | settle_ticks at 0x0
//           | prdata, pready                           |           |
//
// One snapshot is taken per cycle while the input is not stalled; it is registered,
// handled by the phase machine once the result register can take a result, and a
// confirmed key is then registered in the result register.
// Reset is asynchronous and active low; it clears control state and loads
// settle_ticks with 900.
// While a result is stalled, the snapshot in the input register holds and the
// input is stalled once that register is full.
module key_matrix_debounced_scanner #(
    parameter int KEY_TOTAL = kmds_pkg::KEY_TOTAL_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Snapshot input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] key_lines,
    // Result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  key_index,
    output logic [2:0]  key_row,
    output logic [2:0]  key_col,
    output logic [15:0] entropy_count,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kmds_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [63:0] s1_lines_reg;
    logic        in_take;
    logic        step;

    kmds_phase_t phase_reg;
    kmds_phase_t phase_next;
    logic [15:0] delay_left_reg;
    logic [15:0] delay_left_next;
    logic [5:0]  held_key_reg;
    logic [5:0]  held_key_next;
    logic [15:0] entropy_reg;
    logic [15:0] entropy_next;
    logic [15:0] settle_ticks_reg;
    logic        emit;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [5:0]  key_index_reg;
    logic [2:0]  key_row_reg;
    logic [2:0]  key_col_reg;
    logic [15:0] entropy_count_reg;
    logic [5:0]  emit_pos;

    kmds_enc_t   enc;

    // Configuration register access.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SETTLE_TICKS) ? {16'd0, settle_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= SETTLE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_SETTLE_TICKS))
        begin
            settle_ticks_reg <= pwdata[15:0];
        end
    end

    // The held snapshot moves on whenever the result register can take a result.
    assign step          = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall      = s1_valid_reg && !step;
    assign in_take       = in_valid && !in_stall;
    assign s1_valid_next = in_take || (s1_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_lines_reg <= key_lines;
        end
    end

    // Priority search over the registered snapshot.
    kmds_prio_enc #(
        .KEY_TOTAL (KEY_TOTAL)
    ) u_prio_enc (
        .key_lines (s1_lines_reg),
        .held_key  (held_key_reg),
        .enc       (enc)
    );

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                PH_RELEASE:
                begin
                    if (!enc.found)
                    begin
                        phase_next = PH_SETTLE;
                    end
                end
                PH_SETTLE:
                begin
                    if (delay_left_reg == 16'd0)
                    begin
                        phase_next = enc.found ? PH_CONFIRM : PH_SCAN;
                    end
                end
                PH_SCAN:
                begin
                    if (enc.found)
                    begin
                        phase_next = PH_CONFIRM;
                    end
                end
                PH_CONFIRM:
                begin
                    if (delay_left_reg == 16'd0)
                    begin
                        phase_next = enc.held_ok ? PH_RELEASE : PH_SCAN;
                    end
                end
                default:
                begin
                    phase_next = PH_RELEASE;
                end
            endcase
        end
    end

    // Counters, remembered key and the confirm decision.
    always_comb
    begin
        delay_left_next = delay_left_reg;
        held_key_next   = held_key_reg;
        entropy_next    = entropy_reg;
        emit            = 1'b0;
        if (step)
        begin
            case (phase_reg)
                PH_RELEASE:
                begin
                    if (!enc.found)
                    begin
                        delay_left_next = settle_ticks_reg;
                    end
                end
                PH_SETTLE, PH_SCAN:
                begin
                    if (phase_reg == PH_SETTLE && delay_left_reg != 16'd0)
                    begin
                        delay_left_next = delay_left_reg - 16'd1;
                    end
                    else
                    begin
                        // A scan tick: count it and remember the first held key.
                        entropy_next = entropy_reg + 16'd1;
                        if (enc.found)
                        begin
                            held_key_next   = enc.index;
                            delay_left_next = settle_ticks_reg;
                        end
                    end
                end
                PH_CONFIRM:
                begin
                    if (delay_left_reg != 16'd0)
                    begin
                        delay_left_next = delay_left_reg - 16'd1;
                    end
                    else
                    begin
                        emit = enc.held_ok;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RELEASE;
            delay_left_reg <= 16'd0;
            held_key_reg   <= 6'd0;
            entropy_reg    <= 16'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            delay_left_reg <= delay_left_next;
            held_key_reg   <= held_key_next;
            entropy_reg    <= entropy_next;
        end
    end

    // Result register.
    assign emit_pos       = key_pos(held_key_reg);
    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            key_index_reg     <= held_key_reg;
            key_row_reg       <= emit_pos[5:3];
            key_col_reg       <= emit_pos[2:0];
            entropy_count_reg <= entropy_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_index     = key_index_reg;
    assign key_row       = key_row_reg;
    assign key_col       = key_col_reg;
    assign entropy_count = entropy_count_reg;

    // A confirmed key comes only from a finished confirm settle.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase_reg == PH_CONFIRM) && (delay_left_reg == 16'd0))
        else $error("result issued outside a finished confirm settle");

    // After a result the scanner waits for release again.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_RELEASE) && out_valid_reg)
        else $error("result not followed by release wait");

    // Row and column always match the reported table entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({key_row, key_col} == key_pos(key_index)))
        else $error("row and column do not match the key index");

    // The entropy count moves only on a scan tick, by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (entropy_reg != $past(entropy_reg)) |->
            ((entropy_reg == $past(entropy_reg) + 16'd1) && $past(step)
             && ($past(phase_reg) == PH_SCAN || $past(phase_reg) == PH_SETTLE)))
        else $error("entropy count changed outside a scan tick");

    // The input stalls only while the snapshot register holds a waiting request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

// ===== src/kmds_prio_enc.sv =====
// Priority encoder over the key table for one active-low matrix snapshot.
// Depends on kmds_pkg for the table, the key_pos function and kmds_enc_t.
module kmds_prio_enc #(
    parameter int KEY_TOTAL = kmds_pkg::KEY_TOTAL_DEF
) (
    input  logic [63:0]        key_lines,
    input  logic [5:0]         held_key,
    output kmds_pkg::kmds_enc_t enc
);
    import kmds_pkg::*;

    // Keys beyond the table are never looked at.
    localparam int UsedKeys = (KEY_TOTAL > TABLE_SIZE) ? TABLE_SIZE : KEY_TOTAL;

    // Walk down from the lowest priority so that the first held key wins.
    always_comb
    begin
        enc.found = 1'b0;
        enc.index = 6'd0;
        for (int i = UsedKeys - 1; i >= 0; i--)
        begin
            if (!key_lines[KEY_POS[i]])
            begin
                enc.found = 1'b1;
                enc.index = 6'(i);
            end
        end
        // A remembered key outside the used table counts as released.
        enc.held_ok = (held_key < 6'(UsedKeys)) && !key_lines[key_pos(held_key)];
    end

endmodule
